[rtl/lpfd_pkg.sv]
// Shared types and constants for the length-prefixed frame deframer.
// Used by lpfd_core, lpfd_obuf and the top level; depends on nothing.
package lpfd_pkg;

    localparam logic [31:0] HEADER_BYTES    = 32'd12;
    localparam logic [15:0] MAX_LEN_RESET   = 16'd4096;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;
    localparam logic [1:0] KIND_STALE = 2'd3;

    localparam logic [1:0] PH_LENGTH  = 2'd0;
    localparam logic [1:0] PH_SEQ     = 2'd1;
    localparam logic [1:0] PH_PROTO   = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [31:0] protocol_id;
        logic [31:0] sequence_number;
        logic [15:0] payload_length;
        logic        last_of_frame;
    } t_result;

endpackage

[rtl/lpfd_core.sv]
// Deframing state machine: header assembly, length check, sequence filter and payload count.
// Takes one registered byte per enabled cycle; depends on lpfd_pkg.
module lpfd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [7:0]        i_byte,
    input  logic [15:0]       i_max_len,
    output logic              o_res_valid,
    output lpfd_pkg::t_result o_res
);
    import lpfd_pkg::*;

    logic [1:0]  r_phase, n_phase;
    logic [1:0]  r_idx, n_idx;
    logic [23:0] r_shift, n_shift;
    logic [15:0] r_plen, n_plen;
    logic [31:0] r_seq, n_seq;
    logic [31:0] r_proto, n_proto;
    logic [15:0] r_left, n_left;
    logic [31:0] r_last_acc, n_last_acc;
    logic        r_stale, n_stale;
    logic [31:0] word;
    logic        is_stale;
    logic        is_last;

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_shift     = r_shift;
        n_plen      = r_plen;
        n_seq       = r_seq;
        n_proto     = r_proto;
        n_left      = r_left;
        n_last_acc  = r_last_acc;
        n_stale     = r_stale;
        o_res_valid = 1'b0;
        o_res       = '0;
        word        = {i_byte, r_shift};
        is_stale    = r_seq <= r_last_acc;
        is_last     = r_left == 16'd1;
        if (i_en) begin
            if (r_phase != PH_PAYLOAD) begin
                if (r_idx != 2'd3) begin
                    case (r_idx)
                        2'd0:    n_shift[7:0]   = i_byte;
                        2'd1:    n_shift[15:8]  = i_byte;
                        default: n_shift[23:16] = i_byte;
                    endcase
                    n_idx = r_idx + 2'd1;
                end else begin
                    n_idx   = 2'd0;
                    n_shift = '0;
                    unique case (r_phase)
                        PH_LENGTH: begin
                            if (word < HEADER_BYTES || word > {16'd0, i_max_len}) begin
                                o_res_valid         = 1'b1;
                                o_res.kind          = KIND_BAD;
                                o_res.last_of_frame = 1'b1;
                            end else begin
                                n_plen  = word[15:0] - HEADER_BYTES[15:0];
                                n_phase = PH_SEQ;
                            end
                        end
                        PH_SEQ: begin
                            n_seq   = word;
                            n_phase = PH_PROTO;
                        end
                        default: begin
                            n_proto = word;
                            n_left  = r_plen;
                            n_stale = is_stale;
                            if (!is_stale) begin
                                n_last_acc = r_seq;
                            end
                            if (r_plen == 16'd0) begin
                                n_phase               = PH_LENGTH;
                                o_res_valid           = 1'b1;
                                o_res.kind            = is_stale ? KIND_STALE : KIND_EMPTY;
                                o_res.protocol_id     = word;
                                o_res.sequence_number = r_seq;
                                o_res.payload_length  = r_plen;
                                o_res.last_of_frame   = 1'b1;
                            end else begin
                                n_phase = PH_PAYLOAD;
                            end
                        end
                    endcase
                end
            end else begin
                n_left = r_left - 16'd1;
                if (is_last) begin
                    n_phase = PH_LENGTH;
                end
                if (!r_stale || is_last) begin
                    o_res_valid           = 1'b1;
                    o_res.kind            = r_stale ? KIND_STALE : KIND_DATA;
                    o_res.data_byte       = r_stale ? 8'd0 : i_byte;
                    o_res.protocol_id     = r_proto;
                    o_res.sequence_number = r_seq;
                    o_res.payload_length  = r_plen;
                    o_res.last_of_frame   = is_last;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LENGTH;
            r_idx      <= 2'd0;
            r_shift    <= '0;
            r_left     <= '0;
            r_last_acc <= '0;
            r_stale    <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_shift    <= n_shift;
            r_left     <= n_left;
            r_last_acc <= n_last_acc;
            r_stale    <= n_stale;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plen  <= n_plen;
        r_seq   <= n_seq;
        r_proto <= n_proto;
    end

endmodule

[rtl/lpfd_obuf.sv]
// Two-entry result queue whose head register drives the output channel.
// Lets the core keep working while a result waits; depends on lpfd_pkg.
module lpfd_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lpfd_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_full,
    output lpfd_pkg::t_result o_res
);
    import lpfd_pkg::*;

    t_result    r_slot0, r_slot1;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;
    logic [1:0] cnt_after;

    assign o_valid   = r_cnt != 2'd0;
    assign o_full    = r_cnt == 2'd2;
    assign o_res     = r_slot0;
    assign pop       = o_valid && !i_stall;
    assign cnt_after = r_cnt - {1'b0, pop};
    assign n_cnt     = cnt_after + {1'b0, i_push};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_cnt == 2'd2) begin
            r_slot0 <= r_slot1;
        end
        if (i_push) begin
            if (cnt_after == 2'd0) begin
                r_slot0 <= i_res;
            end else begin
                r_slot1 <= i_res;
            end
        end
    end

endmodule

[rtl/length_prefixed_frame_deframer_unit.sv]
// Top level of the length-prefixed frame deframer: input byte register, config register,
// deframing core and output queue. Depends on lpfd_pkg, lpfd_core and lpfd_obuf.
//
// The block takes one stream byte per cycle while the input side is not stalled and gives
// at most one result per byte. Each byte passes an input register, the combinational
// header and counter logic of the core, and a two-entry output queue; the input side
// stalls only when that queue is full and the input register holds a byte. Frames are a
// little-endian 32-bit total length, packet number and protocol word, then the payload.
// A bad length gives one bad-length result, and stale packets give one stale result.
// Write max_frame_length only while the block is idle.
module length_prefixed_frame_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [31:0] o_protocol_id,
    output logic [31:0] o_sequence_number,
    output logic [15:0] o_payload_length,
    output logic        o_last_of_frame
);
    import lpfd_pkg::*;

    logic [15:0] r_max_len;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        advance;
    logic        in_xfer;
    logic        core_valid;
    logic        q_full;
    t_result     core_res;
    t_result     out_res;

    assign advance = r_in_valid && !q_full;
    assign o_stall = r_in_valid && q_full;
    assign in_xfer = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len  <= MAX_LEN_RESET;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_in_byte;
        end
    end

    lpfd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_byte      (r_in_byte),
        .i_max_len   (r_max_len),
        .o_res_valid (core_valid),
        .o_res       (core_res)
    );

    lpfd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (core_valid),
        .i_res   (core_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_full  (q_full),
        .o_res   (out_res)
    );

    assign o_kind            = out_res.kind;
    assign o_data_byte       = out_res.data_byte;
    assign o_protocol_id     = out_res.protocol_id;
    assign o_sequence_number = out_res.sequence_number;
    assign o_payload_length  = out_res.payload_length;
    assign o_last_of_frame   = out_res.last_of_frame;

    a_bad_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_BAD) |->
        (o_last_of_frame && o_payload_length == 16'd0 && o_sequence_number == 32'd0
         && o_protocol_id == 32'd0 && o_data_byte == 8'd0))
        else $error("bad-length result carries frame fields");

    a_nondata_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_DATA) |-> (o_last_of_frame && o_data_byte == 8'd0))
        else $error("non-data result not marked last or carries a byte");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !core_valid)
        else $error("result produced while output queue is full");

endmodule
